// ===== design/lttb_pkg.sv =====
package lttb_pkg;

  // Command codes carried in the cmd field of an input beat.
  typedef enum logic [1:0] {
    CMD_READ   = 2'd0,
    CMD_LEARN  = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  // Status codes returned in the status field of an output beat.
  localparam logic [1:0] STS_NONE    = 2'd0;
  localparam logic [1:0] STS_HIT     = 2'd1;
  localparam logic [1:0] STS_CREATED = 2'd2;
  localparam logic [1:0] STS_FULL    = 2'd3;

  // Search token flags handed from cell to cell along the chain.
  typedef struct packed {
    logic vld;
    logic hit;
    logic empty;
  } tok_t;

  // Operation broadcast to every cell: a clear, or a write or removal once a search has finished.
  typedef struct packed {
    logic clear_all;
    logic wr_sel;
    logic rm_sel;
  } op_t;

endpackage

// ===== design/lttb_in_if.sv =====
interface lttb_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] input_word;
  logic [7:0] next_value;

  modport source (output valid, output cmd, output input_word, output next_value,
                  input ready);
  modport sink (input valid, input cmd, input input_word, input next_value,
                output ready);
endinterface

// ===== design/lttb_out_if.sv =====
interface lttb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] present_state;
  logic [1:0] status;
  logic [4:0] entry_count;

  modport source (output valid, output present_state, output status,
                  output entry_count, input ready);
  modport sink (input valid, input present_state, input status, input entry_count,
                output ready);
endinterface

// ===== design/lttb_cell.sv =====
module lttb_cell #(
  parameter int IW = 8,
  parameter int SW = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  lttb_pkg::tok_t tok_i,
  input  logic [SW-1:0]  tok_nxt_i,
  output lttb_pkg::tok_t tok_o,
  output logic [SW-1:0]  tok_nxt_o,
  input  logic [7:0]     page_i,
  input  logic [IW-1:0]  rise_i,
  input  logic [SW-1:0]  state_i,
  input  logic [IW-1:0]  chg_i,
  input  logic [SW-1:0]  nxt_i,
  input  lttb_pkg::op_t  op_i
);
  import lttb_pkg::*;

  logic [7:0]    tag_q;
  logic [IW-1:0] rise_q, chg_q;
  logic [SW-1:0] state_q, next_q;
  logic          sel_match_q, sel_empty_q;
  tok_t          tok_q;
  logic [SW-1:0] tok_nxt_q;
  logic          match, occupied;

  // An entry matches when it is occupied and every key agrees with the query.
  assign occupied = (tag_q != 8'd0);
  assign match    = occupied && (tag_q == page_i) && (rise_q == rise_i) &&
                    (state_q == state_i) && (chg_q == chg_i);

  // Token stage: pass the flags on and note whether this cell is the first of its kind.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q       <= '0;
      sel_match_q <= 1'b0;
      sel_empty_q <= 1'b0;
    end else begin
      tok_q.vld   <= tok_i.vld;
      tok_q.hit   <= tok_i.hit | match;
      tok_q.empty <= tok_i.empty | ~occupied;
      if (tok_i.vld) begin
        sel_match_q <= match & ~tok_i.hit;
        sel_empty_q <= ~occupied & ~tok_i.empty;
      end
    end
  end

  // The next state of the first matching entry travels with the token.
  always_ff @(posedge clk_i) begin
    if (match && !tok_i.hit) begin
      tok_nxt_q <= next_q;
    end else begin
      tok_nxt_q <= tok_nxt_i;
    end
  end

  assign tok_o     = tok_q;
  assign tok_nxt_o = tok_nxt_q;

  // Tag store: cleared at reset, by a clear or by removal of this entry; loaded when this is the chosen empty slot.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= 8'd0;
    end else if (op_i.clear_all || (op_i.rm_sel && sel_match_q)) begin
      tag_q <= 8'd0;
    end else if (op_i.wr_sel && sel_empty_q) begin
      tag_q <= page_i;
    end
  end

  // Key and next-state store, written when this is the chosen empty slot.
  always_ff @(posedge clk_i) begin
    if (op_i.wr_sel && sel_empty_q) begin
      rise_q  <= rise_i;
      state_q <= state_i;
      chg_q   <= chg_i;
      next_q  <= nxt_i;
    end
  end

endmodule

// ===== design/learned_transition_table_top.sv =====
// Learned transition table.
// Input channel in_i carries one beat per command: cmd, input_word and next_value.
// Output channel out_o returns one beat per command: present_state, status and
// entry_count. The single register page_id is written through cfg_we_i/cfg_wdata_i
// and must only be changed while the block is idle.
// A read, learn or remove whose input word differs from the last one sends a search
// token down a chain of ENTRIES cells, one cell per cycle, and the chosen cell is
// updated as the token leaves the chain. A clear, or a beat with an unchanged input
// word, skips the search and goes straight on to its output beat. One beat is in
// progress at a time and the input is ready again in the cycle after the output beat
// is loaded, so a new beat is taken only once the last one is through.
// The output beat is held in a register, so a new input beat is accepted while an
// earlier result waits; a stalled receiver holds back only the next result.
// Reset empties all entries at once, clears present state and last input, and sets
// page_id to 1.
module learned_transition_table_top #(
  parameter int ENTRIES    = 16,
  parameter int INPUT_BITS = 8,
  parameter int STATE_BITS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  lttb_in_if.sink           in_i,
  lttb_out_if.source        out_o,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_wdata_i
);
  import lttb_pkg::*;

  localparam int IW = (INPUT_BITS < 8) ? INPUT_BITS : 8;
  localparam int SW = (STATE_BITS < 8) ? STATE_BITS : 8;
  localparam int CW = $clog2(ENTRIES + 1);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SEARCH = 3'b010,
    S_DONE   = 3'b100
  } state_e;

  state_e        state_q, state_d;
  logic [7:0]    page_q;
  logic [SW-1:0] present_q, present_d;
  logic [IW-1:0] last_q, last_d;
  logic [CW-1:0] count_q, count_d;
  tok_t          inj_q, inj_d;
  cmd_e          qcmd_q, qcmd_d;
  logic [IW-1:0] qrise_q, qrise_d, qchg_q, qchg_d;
  logic [SW-1:0] qnxt_q, qnxt_d;
  logic [1:0]    res_q, res_d;
  logic          out_vld_q, out_vld_d;
  logic [7:0]    out_state_q, out_state_d;
  logic [1:0]    out_sts_q, out_sts_d;
  logic [4:0]    out_cnt_q, out_cnt_d;
  op_t           op;

  logic [IW-1:0] word, chg;
  logic [CW+4:0] cnt_ext;
  logic [4:0]    cnt_sat;

  tok_t          tok [0:ENTRIES];
  logic [SW-1:0] tnxt [0:ENTRIES];

  // Chain of cells, each holding one table entry.
  assign tok[0]  = inj_q;
  assign tnxt[0] = '0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    lttb_cell #(.IW(IW), .SW(SW)) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .tok_i     (tok[g]),
      .tok_nxt_i (tnxt[g]),
      .tok_o     (tok[g+1]),
      .tok_nxt_o (tnxt[g+1]),
      .page_i    (page_q),
      .rise_i    (qrise_q),
      .state_i   (present_q),
      .chg_i     (qchg_q),
      .nxt_i     (qnxt_q),
      .op_i      (op)
    );
  end

  assign word = in_i.input_word[IW-1:0];
  assign chg  = word ^ last_q;

  // Entry count as shown on the output, saturating at the field's limit.
  assign cnt_ext = (CW + 5)'(count_q);
  assign cnt_sat = (cnt_ext > (CW + 5)'(31)) ? 5'd31 : cnt_ext[4:0];

  assign in_i.ready          = (state_q == S_IDLE);
  assign out_o.valid         = out_vld_q;
  assign out_o.present_state = out_state_q;
  assign out_o.status        = out_sts_q;
  assign out_o.entry_count   = out_cnt_q;

  // Sequencer: accept a beat, run the search, apply the result, hand it out.
  always_comb begin
    state_d     = state_q;
    present_d   = present_q;
    last_d      = last_q;
    count_d     = count_q;
    inj_d       = '0;
    qcmd_d      = qcmd_q;
    qrise_d     = qrise_q;
    qchg_d      = qchg_q;
    qnxt_d      = qnxt_q;
    res_d       = res_q;
    op          = '0;
    out_vld_d   = out_vld_q && !out_o.ready;
    out_state_d = out_state_q;
    out_sts_d   = out_sts_q;
    out_cnt_d   = out_cnt_q;
    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          if (cmd_e'(in_i.cmd) == CMD_CLEAR) begin
            op.clear_all = 1'b1;
            res_d        = (count_q != '0) ? STS_HIT : STS_NONE;
            count_d      = '0;
            state_d      = S_DONE;
          end else if (chg == '0) begin
            res_d   = STS_NONE;
            state_d = S_DONE;
          end else begin
            qcmd_d    = cmd_e'(in_i.cmd);
            qchg_d    = chg;
            qrise_d   = chg & word;
            qnxt_d    = in_i.next_value[SW-1:0];
            last_d    = word;
            inj_d.vld = 1'b1;
            state_d   = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        if (tok[ENTRIES].vld) begin
          res_d   = STS_NONE;
          state_d = S_DONE;
          case (qcmd_q)
            CMD_READ: begin
              if (tok[ENTRIES].hit) begin
                present_d = tnxt[ENTRIES];
                res_d     = STS_HIT;
              end
            end
            CMD_LEARN: begin
              if (tok[ENTRIES].hit) begin
                res_d = STS_HIT;
              end else if (page_q != 8'd0) begin
                if (tok[ENTRIES].empty) begin
                  op.wr_sel = 1'b1;
                  count_d   = CW'(count_q + 1'b1);
                  res_d     = STS_CREATED;
                end else begin
                  res_d = STS_FULL;
                end
              end
            end
            CMD_REMOVE: begin
              if (tok[ENTRIES].hit) begin
                op.rm_sel = 1'b1;
                count_d   = CW'(count_q - 1'b1);
                res_d     = STS_HIT;
              end
            end
            default: begin
              res_d = STS_NONE;
            end
          endcase
        end
      end
      S_DONE: begin
        if (!out_vld_q || out_o.ready) begin
          out_vld_d   = 1'b1;
          out_state_d = 8'(present_q);
          out_sts_d   = res_q;
          out_cnt_d   = cnt_sat;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      page_q    <= 8'd1;
      present_q <= '0;
      last_q    <= '0;
      count_q   <= '0;
      inj_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      present_q <= present_d;
      last_q    <= last_d;
      count_q   <= count_d;
      inj_q     <= inj_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i) begin
        page_q <= cfg_wdata_i;
      end
    end
  end

  // Query and result payload.
  always_ff @(posedge clk_i) begin
    qcmd_q      <= qcmd_d;
    qrise_q     <= qrise_d;
    qchg_q      <= qchg_d;
    qnxt_q      <= qnxt_d;
    res_q       <= res_d;
    out_state_q <= out_state_d;
    out_sts_q   <= out_sts_d;
    out_cnt_q   <= out_cnt_d;
  end

  // An accepted beat always leaves the idle state.
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> state_q == S_SEARCH || state_q == S_DONE)
    else $error("accepted beat did not start work");

  // The token only leaves the chain while a search is running.
  a_tok_in_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok[ENTRIES].vld |-> state_q == S_SEARCH)
    else $error("search token seen outside a search");

  // A slot is written only when no match exists and an empty slot was seen.
  a_write_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op.wr_sel |-> !tok[ENTRIES].hit && tok[ENTRIES].empty)
    else $error("slot written without a free entry");

  // The occupancy count never exceeds the table size.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CW + 5)'(count_q) <= (CW + 5)'(ENTRIES))
    else $error("entry count out of range");

endmodule
